### hdl/assert_macros.svh
// Assertion macros shared by the light gate timer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LGIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("light gate timer assertion failed");
`define LGIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("light gate timer assertion failed");
`else
`define LGIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LGIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/lgit_pkg.sv
// Types, constants and helper functions of the light gate interval timer.
// No dependencies; used by the core, lgit_ctrl and the testbench.
`default_nettype none

package lgit_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD    = 2'd2;

    localparam logic [CFG_W-1:0] CHECK_TIMEOUT_RST = 16'd5000;
    localparam logic [CFG_W-1:0] REARM_WINDOW_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] RESET_HOLD_RST    = 16'd3000;

    localparam logic [9:0] MS_MAX  = 10'd999;
    localparam logic [5:0] SEC_MAX = 6'd59;
    localparam logic [6:0] MIN_MAX = 7'd99;

    typedef enum logic [2:0] {
        PH_CHECK1 = 3'd0,
        PH_CHECK2 = 3'd1,
        PH_FAULT  = 3'd2,
        PH_ARMED  = 3'd3,
        PH_WINDOW = 3'd4,
        PH_WAIT2  = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef logic [TIMER_W-1:0] t_timer;

    typedef struct packed {
        logic tick_ms;
        logic gate1_edge;
        logic gate2_edge;
        logic button_level;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] check_timeout;
        logic [CFG_W-1:0] rearm_window;
        logic [CFG_W-1:0] reset_hold;
    } t_cfg;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
    } t_time;

    typedef struct packed {
        t_phase phase;
        logic   sensor_fault;
        logic   result_valid;
        t_time  elapsed;
    } t_result;

    function automatic t_timer sat_inc(input t_timer v);
        return (v == '1) ? v : v + t_timer'(1);
    endfunction

    function automatic logic reached(input t_timer t, input logic [CFG_W-1:0] c);
        return CMP_W'(t) >= CMP_W'(c);
    endfunction

    function automatic t_time advance_time(input t_time t);
        t_time r;
        r = t;
        if (t.minutes >= MIN_MAX && t.seconds >= SEC_MAX && t.millis >= MS_MAX) begin
            r = t;
        end else if (t.millis < MS_MAX) begin
            r.millis = t.millis + 10'd1;
        end else begin
            r.millis = '0;
            if (t.seconds < SEC_MAX) begin
                r.seconds = t.seconds + 6'd1;
            end else begin
                r.seconds = '0;
                if (t.minutes < MIN_MAX) begin
                    r.minutes = t.minutes + 7'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/lgit_in_if.sv
// Input channel of the light gate timer: valid, ready and one sensor word.
// Depends on nothing.
`default_nettype none

interface lgit_in_if;
    logic valid;
    logic ready;
    logic tick_ms;
    logic gate1_edge;
    logic gate2_edge;
    logic button_level;

    modport source (output valid, tick_ms, gate1_edge, gate2_edge, button_level,
                    input ready);
    modport sink (input valid, tick_ms, gate1_edge, gate2_edge, button_level,
                  output ready);
endinterface

`default_nettype wire

### hdl/lgit_out_if.sv
// Output channel of the light gate timer: valid, ready and one status word.
// Depends on nothing.
`default_nettype none

interface lgit_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       sensor_fault;
    logic       result_valid;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;

    modport source (output valid, phase, sensor_fault, result_valid, minutes, seconds,
                    millis, input ready);
    modport sink (input valid, phase, sensor_fault, result_valid, minutes, seconds,
                  millis, output ready);
endinterface

`default_nettype wire

### hdl/light_gate_interval_timer_core.sv
// Top level of the light gate interval timer: channels, configuration, output register.
// Depends on lgit_pkg, lgit_in_if, lgit_out_if, lgit_ctrl and assert_macros.svh.
//
// Use: every sensor word on i_in_ch carries the 1 ms tick flag, the edge flags of
// both light barriers and the button level. For every accepted word the block
// returns exactly one status word on o_out_ch: phase, sensor fault flag, a flag
// that marks the word completing a measurement, and the elapsed minutes, seconds
// and milliseconds.
// The status word is registered: the one for a sensor word accepted at one edge is
// valid after that edge. One word is accepted every cycle while the output
// register is empty or being read in the same cycle; the phase, timer and time
// registers update in the cycle of acceptance.
// When the receiver stalls, the status word is held in the output register and
// i_in_ch.ready falls until the word is taken.
// Synchronous reset puts the block in the sensor-1 self test with all timers and
// time counters at zero and loads the configuration defaults of 5000, 1000 and
// 3000 ms. Unused indices are ignored. Write configuration through i_cfg_we, i_cfg_idx
// and i_cfg_data only while no word is in flight; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module light_gate_interval_timer_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lgit_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lgit_pkg::CFG_W-1:0]         i_cfg_data,
    lgit_in_if.sink                                 i_in_ch,
    lgit_out_if.source                              o_out_ch
);

    lgit_pkg::t_cfg    r_cfg;
    lgit_pkg::t_item   item;
    lgit_pkg::t_result res;
    lgit_pkg::t_result r_out_data;
    logic              r_out_valid;
    logic              in_ready;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_timeout <= lgit_pkg::CHECK_TIMEOUT_RST;
            r_cfg.rearm_window  <= lgit_pkg::REARM_WINDOW_RST;
            r_cfg.reset_hold    <= lgit_pkg::RESET_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lgit_pkg::CFG_CHECK_TIMEOUT: r_cfg.check_timeout <= i_cfg_data;
                lgit_pkg::CFG_REARM_WINDOW:  r_cfg.rearm_window  <= i_cfg_data;
                lgit_pkg::CFG_RESET_HOLD:    r_cfg.reset_hold    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready        = !r_out_valid || o_out_ch.ready;
    assign accept          = i_in_ch.valid && in_ready;
    assign i_in_ch.ready   = in_ready;

    assign item.tick_ms      = i_in_ch.tick_ms;
    assign item.gate1_edge   = i_in_ch.gate1_edge;
    assign item.gate2_edge   = i_in_ch.gate2_edge;
    assign item.button_level = i_in_ch.button_level;

    lgit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= res;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.phase        = r_out_data.phase;
    assign o_out_ch.sensor_fault = r_out_data.sensor_fault;
    assign o_out_ch.result_valid = r_out_data.result_valid;
    assign o_out_ch.minutes      = r_out_data.elapsed.minutes;
    assign o_out_ch.seconds      = r_out_data.elapsed.seconds;
    assign o_out_ch.millis       = r_out_data.elapsed.millis;

    `LGIT_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, accept, r_out_valid)
    `LGIT_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !r_out_valid, in_ready)
    `LGIT_ASSERT_NOW(a_result_done, i_clk, i_rst_n,
        r_out_valid && r_out_data.result_valid,
        r_out_data.phase == lgit_pkg::PH_DONE && !r_out_data.sensor_fault)

endmodule

`default_nettype wire

### hdl/lgit_ctrl.sv
// Phase state machine, timers and elapsed-time counters of the light gate timer.
// Depends on lgit_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lgit_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire lgit_pkg::t_item i_item,
    input  wire lgit_pkg::t_cfg  i_cfg,
    output lgit_pkg::t_result    o_res
);

    lgit_pkg::t_phase r_phase, n_phase;
    lgit_pkg::t_timer r_phase_tmr, n_phase_tmr;
    lgit_pkg::t_timer r_hold_tmr, n_hold_tmr;
    lgit_pkg::t_time  r_time, n_time;
    lgit_pkg::t_time  time_adv;
    lgit_pkg::t_timer phase_tmr_inc;
    logic             restart;
    logic             check_edge;
    logic             done_now;

    always_comb begin
        n_hold_tmr = r_hold_tmr;
        if (i_item.tick_ms) begin
            n_hold_tmr = i_item.button_level ? lgit_pkg::sat_inc(r_hold_tmr) : '0;
        end
    end

    assign restart       = lgit_pkg::reached(n_hold_tmr, i_cfg.reset_hold);
    assign time_adv      = i_item.tick_ms ? lgit_pkg::advance_time(r_time) : r_time;
    assign phase_tmr_inc = i_item.tick_ms ? lgit_pkg::sat_inc(r_phase_tmr) : r_phase_tmr;
    assign check_edge    = (r_phase == lgit_pkg::PH_CHECK1) ? i_item.gate1_edge
                                                            : i_item.gate2_edge;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (restart) begin
            n_phase = lgit_pkg::PH_CHECK1;
        end else begin
            unique case (r_phase)
                lgit_pkg::PH_CHECK1, lgit_pkg::PH_CHECK2: begin
                    if (lgit_pkg::reached(phase_tmr_inc, i_cfg.check_timeout)) begin
                        n_phase = lgit_pkg::PH_FAULT;
                    end else if (check_edge) begin
                        n_phase = (r_phase == lgit_pkg::PH_CHECK1) ? lgit_pkg::PH_CHECK2
                                                                   : lgit_pkg::PH_ARMED;
                    end
                end
                lgit_pkg::PH_FAULT: begin
                    if (i_item.button_level) n_phase = lgit_pkg::PH_CHECK1;
                end
                lgit_pkg::PH_ARMED: begin
                    if (i_item.gate1_edge) n_phase = lgit_pkg::PH_WINDOW;
                end
                lgit_pkg::PH_WINDOW: begin
                    if (!i_item.gate1_edge && i_item.tick_ms &&
                        lgit_pkg::reached(r_phase_tmr, i_cfg.rearm_window)) begin
                        n_phase = lgit_pkg::PH_WAIT2;
                    end
                end
                lgit_pkg::PH_WAIT2: begin
                    if (i_item.gate2_edge) n_phase = lgit_pkg::PH_DONE;
                end
                lgit_pkg::PH_DONE: begin
                    if (i_item.button_level) n_phase = lgit_pkg::PH_ARMED;
                end
                default: n_phase = lgit_pkg::PH_CHECK1;
            endcase
        end
    end

    // Timers, time counters and the completion flag.
    always_comb begin
        n_phase_tmr = r_phase_tmr;
        n_time      = r_time;
        done_now    = 1'b0;
        if (restart) begin
            n_phase_tmr = '0;
            n_time      = '0;
        end else begin
            unique case (r_phase)
                lgit_pkg::PH_CHECK1, lgit_pkg::PH_CHECK2: begin
                    n_phase_tmr = (n_phase != r_phase) ? '0 : phase_tmr_inc;
                end
                lgit_pkg::PH_FAULT, lgit_pkg::PH_DONE: begin
                    if (i_item.button_level) n_phase_tmr = '0;
                end
                lgit_pkg::PH_ARMED: begin
                    if (i_item.gate1_edge) begin
                        n_phase_tmr = '0;
                        n_time      = '0;
                    end
                end
                lgit_pkg::PH_WINDOW: begin
                    n_time = time_adv;
                    if (i_item.gate1_edge || n_phase != r_phase) begin
                        n_phase_tmr = '0;
                    end else begin
                        n_phase_tmr = phase_tmr_inc;
                    end
                end
                lgit_pkg::PH_WAIT2: begin
                    n_time   = time_adv;
                    done_now = i_item.gate2_edge;
                end
                default: begin
                    n_phase_tmr = '0;
                    n_time      = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lgit_pkg::PH_CHECK1;
            r_phase_tmr <= '0;
            r_hold_tmr  <= '0;
            r_time      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_phase_tmr <= n_phase_tmr;
            r_hold_tmr  <= restart ? '0 : n_hold_tmr;
            r_time      <= n_time;
        end
    end

    always_comb begin
        o_res.phase        = n_phase;
        o_res.sensor_fault = (n_phase == lgit_pkg::PH_FAULT);
        o_res.result_valid = done_now;
        o_res.elapsed      = n_time;
    end

    `LGIT_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, i_step && restart,
        r_phase == lgit_pkg::PH_CHECK1 && r_hold_tmr == '0 && r_time == '0)
    `LGIT_ASSERT_NOW(a_done_from_wait2, i_clk, i_rst_n, done_now,
        r_phase == lgit_pkg::PH_WAIT2 && !restart)
    `LGIT_ASSERT_NOW(a_time_in_range, i_clk, i_rst_n, 1'b1,
        r_time.millis <= lgit_pkg::MS_MAX && r_time.seconds <= lgit_pkg::SEC_MAX &&
        r_time.minutes <= lgit_pkg::MIN_MAX)
    `LGIT_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_step,
        $stable(r_phase) && $stable(r_time) && $stable(r_hold_tmr))

endmodule

`default_nettype wire

### tb/light_gate_interval_timer_core_test.sv
// Self-checking testbench of light_gate_interval_timer_core: directed table, random words
// and one short timed run, each status word checked against a table row or a gate model.
// Depends on lgit_pkg, lgit_in_if, lgit_out_if and the core itself.
module light_gate_interval_timer_core_test;
    import lgit_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [3:0] W_NONE   = 4'b0000;
    localparam logic [3:0] W_TICK   = 4'b1000;
    localparam logic [3:0] W_GATE1  = 4'b0100;
    localparam logic [3:0] W_GATE2  = 4'b0010;
    localparam logic [3:0] W_BUTTON = 4'b0001;

    localparam t_time   T0      = '0;
    localparam t_result NO_WANT = '0;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [3:0]           word;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 typed;
        t_result              want;
    } t_stim_row;

    localparam t_stim_row PLAN [31] = '{
        '{ROW_WORD, W_NONE, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK1, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK1, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK | W_GATE1 | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_CHECK2, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK2, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_ARMED, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_ARMED, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_WINDOW, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_WINDOW, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd1}}},
        '{ROW_WORD, W_TICK | W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_WINDOW, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd2}}},
        '{ROW_CFG, W_NONE, CFG_REARM_WINDOW, 16'd0, 1'b0, NO_WANT},
        '{ROW_WORD, W_TICK | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_WAIT2, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd3}}},
        '{ROW_WORD, W_TICK | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_DONE, 1'b0, 1'b1, '{7'd0, 6'd0, 10'd4}}},
        '{ROW_WORD, W_TICK | W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_DONE, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd4}}},
        '{ROW_WORD, W_BUTTON, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_ARMED, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd4}}},
        '{ROW_CFG, W_NONE, CFG_CHECK_TIMEOUT, 16'd1, 1'b0, NO_WANT},
        '{ROW_CFG, W_NONE, CFG_RESET_HOLD, 16'd2, 1'b0, NO_WANT},
        '{ROW_WORD, W_TICK | W_BUTTON, CFG_CHECK_TIMEOUT, 16'd0, 1'b0, NO_WANT},
        '{ROW_WORD, W_TICK | W_BUTTON | W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_CHECK1, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_FAULT, 1'b1, 1'b0, T0}},
        '{ROW_WORD, W_TICK | W_GATE1 | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_FAULT, 1'b1, 1'b0, T0}},
        '{ROW_WORD, W_BUTTON, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK1, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK | W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_FAULT, 1'b1, 1'b0, T0}},
        '{ROW_WORD, W_BUTTON, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK1, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_GATE1, CFG_CHECK_TIMEOUT, 16'd0, 1'b1, '{PH_CHECK2, 1'b0, 1'b0, T0}},
        '{ROW_CFG, W_NONE, CFG_CHECK_TIMEOUT, 16'hFFFF, 1'b0, NO_WANT},
        '{ROW_CFG, W_NONE, CFG_REARM_WINDOW, 16'hFFFF, 1'b0, NO_WANT},
        '{ROW_CFG, W_NONE, CFG_RESET_HOLD, 16'hFFFF, 1'b0, NO_WANT},
        '{ROW_CFG, W_NONE, CFG_UNUSED, 16'hFFFF, 1'b0, NO_WANT},
        '{ROW_WORD, W_TICK | W_GATE2, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_ARMED, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK | W_GATE1 | W_GATE2 | W_BUTTON, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_WINDOW, 1'b0, 1'b0, T0}},
        '{ROW_WORD, W_TICK, CFG_CHECK_TIMEOUT, 16'd0, 1'b1,
          '{PH_WINDOW, 1'b0, 1'b0, '{7'd0, 6'd0, 10'd1}}}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    lgit_in_if  in_ch ();
    lgit_out_if out_ch ();

    light_gate_interval_timer_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_ch   (in_ch),
        .o_out_ch  (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_phase           gate_ph;
    t_timer           gate_timer;
    t_timer           press_ms;
    logic [9:0]       el_ms;
    logic [5:0]       el_sec;
    logic [6:0]       el_min;
    logic [CFG_W-1:0] lim_check;
    logic [CFG_W-1:0] lim_window;
    logic [CFG_W-1:0] lim_hold;

    t_result     status_due[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned src_gap_max = 6;
    int unsigned press_left = 0;
    bit          rush = 1'b0;

    function automatic t_timer timer_up(input t_timer v);
        return (v == {TIMER_W{1'b1}}) ? v : v + t_timer'(1);
    endfunction

    function automatic void zero_clock();
        el_ms  = '0;
        el_sec = '0;
        el_min = '0;
    endfunction

    function automatic void restart_gate();
        gate_ph    = PH_CHECK1;
        gate_timer = '0;
        press_ms   = '0;
        zero_clock();
    endfunction

    function automatic void run_clock();
        if (el_min == 7'd99 && el_sec == 6'd59 && el_ms == 10'd999) return;
        if (el_ms != 10'd999) begin
            el_ms = el_ms + 10'd1;
        end else begin
            el_ms = '0;
            if (el_sec != 6'd59) begin
                el_sec = el_sec + 6'd1;
            end else begin
                el_sec = '0;
                if (el_min != 7'd99) el_min = el_min + 7'd1;
            end
        end
    endfunction

    function automatic t_result predict_status(input t_item w);
        t_result r;
        logic    closes;
        closes = 1'b0;
        if (w.tick_ms) press_ms = w.button_level ? timer_up(press_ms) : '0;
        if (press_ms >= lim_hold) begin
            restart_gate();
        end else begin
            case (gate_ph)
                PH_CHECK1, PH_CHECK2: begin
                    if (w.tick_ms) gate_timer = timer_up(gate_timer);
                    if (gate_timer >= lim_check) begin
                        gate_ph    = PH_FAULT;
                        gate_timer = '0;
                    end else if (gate_ph == PH_CHECK1 ? w.gate1_edge : w.gate2_edge) begin
                        gate_ph    = (gate_ph == PH_CHECK1) ? PH_CHECK2 : PH_ARMED;
                        gate_timer = '0;
                    end
                end
                PH_FAULT: begin
                    if (w.button_level) begin
                        gate_ph    = PH_CHECK1;
                        gate_timer = '0;
                    end
                end
                PH_ARMED: begin
                    if (w.gate1_edge) begin
                        zero_clock();
                        gate_timer = '0;
                        gate_ph    = PH_WINDOW;
                    end
                end
                PH_WINDOW: begin
                    if (w.tick_ms) run_clock();
                    if (w.gate1_edge) begin
                        gate_timer = '0;
                    end else if (w.tick_ms) begin
                        if (gate_timer >= lim_window) begin
                            gate_ph    = PH_WAIT2;
                            gate_timer = '0;
                        end else begin
                            gate_timer = timer_up(gate_timer);
                        end
                    end
                end
                PH_WAIT2: begin
                    if (w.tick_ms) run_clock();
                    if (w.gate2_edge) begin
                        closes  = 1'b1;
                        gate_ph = PH_DONE;
                    end
                end
                PH_DONE: begin
                    if (w.button_level) begin
                        gate_ph    = PH_ARMED;
                        gate_timer = '0;
                    end
                end
                default: begin
                    restart_gate();
                end
            endcase
        end
        r.phase           = gate_ph;
        r.sensor_fault    = (gate_ph == PH_FAULT);
        r.result_valid    = closes;
        r.elapsed.minutes = el_min;
        r.elapsed.seconds = el_sec;
        r.elapsed.millis  = el_ms;
        return r;
    endfunction

    // Most words follow what the current phase waits for; a few are pure noise, and now
    // and then the button is held for a run of ticks that can force a restart.
    function automatic t_item pick_word();
        t_item w;
        w = t_item'(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0) return w;
        if (press_left == 0 && $urandom_range(0, 99) == 0) begin
            press_left = (lim_hold < 16) ? int'(lim_hold) + 1 : 16;
        end
        w.tick_ms      = 1'($urandom_range(0, 1));
        w.gate1_edge   = $urandom_range(0, 99) <
                         ((gate_ph == PH_CHECK1 || gate_ph == PH_ARMED) ? 25 : 4);
        w.gate2_edge   = $urandom_range(0, 99) <
                         ((gate_ph == PH_CHECK2 || gate_ph == PH_WAIT2) ? 25 : 4);
        w.button_level = $urandom_range(0, 99) <
                         ((gate_ph == PH_FAULT || gate_ph == PH_DONE) ? 30 : 2);
        if (press_left != 0) begin
            w.tick_ms      = 1'b1;
            w.button_level = 1'b1;
            press_left--;
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_word(input logic [3:0] w, input int unsigned gap, input logic typed,
                             input t_result want);
        t_result due;
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.tick_ms, in_ch.gate1_edge, in_ch.gate2_edge, in_ch.button_level} <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        due = predict_status(t_item'(w));
        status_due.push_back(typed ? want : due);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CHECK_TIMEOUT: lim_check  = data;
            CFG_REARM_WINDOW:  lim_window = data;
            CFG_RESET_HOLD:    lim_hold   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (status_due.size() == 0) begin
                $error("status word arrived with none expected");
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("phase", want.phase, out_ch.phase);
                check_field("sensor_fault", want.sensor_fault, out_ch.sensor_fault);
                check_field("result_valid", want.result_valid, out_ch.result_valid);
                check_field("minutes", want.elapsed.minutes, out_ch.minutes);
                check_field("seconds", want.elapsed.seconds, out_ch.seconds);
                check_field("millis", want.elapsed.millis, out_ch.millis);
            end
        end
    end

    // The receiver stalls once for a long stretch so that the output register fills and
    // the input side must back off.
    initial begin
        int unsigned gap;
        int unsigned taken;
        int unsigned snk_gap_max;
        bit          held_off;
        out_ch.ready = 1'b0;
        taken        = 0;
        snk_gap_max  = 6;
        held_off     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (taken % 40 == 0) snk_gap_max = $urandom_range(0, 1) ? 6 : 0;
            if (rush) begin
                gap = 0;
            end else if (!held_off && taken >= 300) begin
                gap      = 90;
                held_off = 1'b1;
            end else begin
                gap = $urandom_range(0, snk_gap_max);
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            taken++;
        end
    end

    initial begin
        logic [CFG_W-1:0] chk;
        logic [CFG_W-1:0] win;
        logic [CFG_W-1:0] hold;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_CHECK_TIMEOUT;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.tick_ms      = 1'b0;
        in_ch.gate1_edge   = 1'b0;
        in_ch.gate2_edge   = 1'b0;
        in_ch.button_level = 1'b0;
        lim_check          = CHECK_TIMEOUT_RST;
        lim_window         = REARM_WINDOW_RST;
        lim_hold           = RESET_HOLD_RST;
        restart_gate();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(PLAN); i++) begin
            if (PLAN[i].kind == ROW_CFG) begin
                settle();
                set_reg(PLAN[i].idx, PLAN[i].data);
            end else begin
                push_word(PLAN[i].word, $urandom_range(0, 6), PLAN[i].typed, PLAN[i].want);
            end
        end

        for (int s = 0; s < 5; s++) begin
            settle();
            case (s)
                0: begin
                    chk  = 16'd1;
                    win  = 16'd0;
                    hold = 16'd1;
                end
                4: begin
                    chk  = 16'hFFFF;
                    win  = 16'd0;
                    hold = 16'hFFFF;
                end
                default: begin
                    chk  = 16'($urandom_range(2, 24));
                    win  = 16'($urandom_range(0, 12));
                    hold = 16'($urandom_range(2, 10));
                end
            endcase
            set_reg(CFG_CHECK_TIMEOUT, chk);
            set_reg(CFG_REARM_WINDOW, win);
            set_reg(CFG_RESET_HOLD, hold);
            for (int n = 0; n < 120; n++) begin
                if (n % 32 == 0) src_gap_max = $urandom_range(0, 1) ? 6 : 0;
                push_word(pick_word(), $urandom_range(0, src_gap_max), 1'b0, NO_WANT);
            end
        end

        // Restart, then time a short run with no idling on either side.
        settle();
        set_reg(CFG_RESET_HOLD, 16'd1);
        push_word(W_TICK | W_BUTTON, 0, 1'b0, NO_WANT);
        settle();
        set_reg(CFG_CHECK_TIMEOUT, 16'hFFFF);
        set_reg(CFG_REARM_WINDOW, 16'd0);
        set_reg(CFG_RESET_HOLD, 16'hFFFF);
        rush = 1'b1;
        push_word(W_GATE1, 0, 1'b0, NO_WANT);
        push_word(W_GATE2, 0, 1'b0, NO_WANT);
        push_word(W_GATE1, 0, 1'b0, NO_WANT);
        push_word(W_TICK, 0, 1'b0, NO_WANT);
        repeat (20) push_word(W_TICK, 0, 1'b0, NO_WANT);
        push_word(W_TICK | W_GATE2, 0, 1'b0, NO_WANT);
        rush = 1'b0;

        settle();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
